// ----- sv/dsvd_pkg.sv -----
// Shared constants, tables and types for the depth to velocity and density block.
`default_nettype none
package dsvd_pkg;
	localparam int LayerCountDefault = 9;
	localparam int TableSlots = 16;
	localparam logic [19:0] RhoBaseQ8 = 20'd477440;
	localparam logic [19:0] RhoLowQ8 = 20'd527360;
	localparam logic [16:0] RhoSpanQ8 = 17'd112640;
	localparam int PW = 21;
	localparam int TW = 64;
	localparam int RW = 32;

	typedef logic [15:0] dep_m_t;
	typedef logic [12:0] vp_ms_t;

	// Breakpoint depth in metres
	function automatic dep_m_t layer_depth(input logic [3:0] idx);
		dep_m_t r;
		unique case (idx)
			4'd0: r = 16'd1000;
			4'd1: r = 16'd5000;
			4'd2: r = 16'd6000;
			4'd3: r = 16'd10000;
			4'd4: r = 16'd15500;
			4'd5: r = 16'd16500;
			4'd6: r = 16'd22000;
			4'd7: r = 16'd31000;
			4'd8: r = 16'd33000;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// Breakpoint P speed in m/s
	function automatic vp_ms_t layer_vp(input logic [3:0] idx);
		vp_ms_t r;
		unique case (idx)
			4'd0: r = 13'd5000;
			4'd1: r = 13'd5500;
			4'd2: r = 13'd6300;
			4'd3: r = 13'd6300;
			4'd4: r = 13'd6400;
			4'd5: r = 13'd6700;
			4'd6: r = 13'd6750;
			4'd7: r = 13'd6800;
			4'd8: r = 13'd7800;
			default: r = 13'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- sv/dsvd_pvel.sv -----
// Piecewise linear P speed interpolation pipeline (segment find, multiply, divide).
`default_nettype none
module dsvd_pvel
	import dsvd_pkg::*;
#(
	parameter int LAYER_COUNT = LayerCountDefault
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] depth_q8,
	output logic [PW-1:0]    p_out
);
	localparam int N = (LAYER_COUNT < 1) ? 1 : ((LAYER_COUNT > TableSlots) ? TableSlots
		: LAYER_COUNT);
	localparam int QB = 34;

	// Stage 1: locate the segment
	logic [3:0] seg_c;
	logic       found_c;
	always_comb begin
		seg_c = 4'(N);
		found_c = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if ($signed({1'b0, layer_depth(4'(i)), 8'd0}) > $signed(depth_q8)) begin
				seg_c = 4'(i);
				found_c = 1'b1;
			end
		end
	end

	logic [3:0]  seg_s1;
	logic        fnd_s1;
	logic [31:0] d_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= seg_c;
			fnd_s1 <= found_c;
			d_s1 <= depth_q8;
		end
	end

	// Stage 2: delta times speed step
	logic [3:0]         lo_c;
	logic signed [33:0] delta_c;
	logic signed [14:0] dv_c;
	logic [16:0]        dd_c;
	logic               flat_c;
	logic [PW-1:0]      base_c;
	always_comb begin
		lo_c = (seg_s1 == 4'd0) ? 4'd0 : seg_s1 - 4'd1;
		delta_c = $signed({{2{d_s1[31]}}, d_s1}) - $signed({10'd0, layer_depth(lo_c), 8'd0});
		dv_c = $signed({2'b0, layer_vp(seg_s1)}) - $signed({2'b0, layer_vp(lo_c)});
		dd_c = {1'b0, layer_depth(seg_s1)} - {1'b0, layer_depth(lo_c)};
		flat_c = !fnd_s1 || (seg_s1 == 4'd0) || dd_c[16] || (dd_c == 17'd0);
		base_c = fnd_s1 ? {layer_vp(lo_c), 8'd0} : {layer_vp(4'(N - 1)), 8'd0};
	end

	logic signed [48:0] prod_s2;
	logic [15:0]        dd_s2;
	logic               flat_s2;
	logic [PW-1:0]      base_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= 49'(delta_c) * 49'(dv_c);
			dd_s2 <= dd_c[15:0];
			flat_s2 <= flat_c;
			base_s2 <= base_c;
		end
	end

	// Stage 3..: restoring divide of 2*|prod| + dd by 2*dd, one bit per stage
	logic [QB:0]   num_c;
	logic          neg_c;
	always_comb begin
		neg_c = prod_s2[48];
		num_c = (QB + 1)'(neg_c ? -prod_s2 : prod_s2);
		num_c = (QB + 1)'({num_c, 1'b0} + {19'd0, dd_s2});
	end

	logic [QB:0]   rem_q [QB+2];
	logic [QB:0]   quo_q [QB+2];
	logic [16:0]   den_q [QB+2];
	logic          neg_q [QB+2];
	logic          flat_q [QB+2];
	logic [PW-1:0] base_q [QB+2];

	always_comb begin
		rem_q[0] = '0;
		quo_q[0] = num_c;
		den_q[0] = {dd_s2, 1'b0};
		neg_q[0] = neg_c;
		flat_q[0] = flat_s2;
		base_q[0] = base_s2;
	end

	for (genvar k = 0; k <= QB; k++) begin : g_div
		logic [QB+1:0] trial;
		assign trial = {rem_q[k], quo_q[k][QB]} - (QB + 2)'(den_q[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[QB+1]) begin
					rem_q[k+1] <= trial[QB:0];
					quo_q[k+1] <= {quo_q[k][QB-1:0], 1'b1};
				end else begin
					rem_q[k+1] <= {rem_q[k][QB-1:0], quo_q[k][QB]};
					quo_q[k+1] <= {quo_q[k][QB-1:0], 1'b0};
				end
				den_q[k+1] <= den_q[k];
				neg_q[k+1] <= neg_q[k];
				flat_q[k+1] <= flat_q[k];
				base_q[k+1] <= base_q[k];
			end
		end
	end

	// Apply sign, add base, clamp at zero
	logic signed [QB+2:0] sum_c;
	always_comb begin
		sum_c = $signed({{2{1'b0}}, base_q[QB+1]}) ;
		if (!flat_q[QB+1]) begin
			sum_c = neg_q[QB+1] ? sum_c - $signed({2'b0, quo_q[QB+1]})
				: sum_c + $signed({2'b0, quo_q[QB+1]});
		end
	end
	assign p_out = sum_c[QB+2] ? '0 : PW'(sum_c);
endmodule
`default_nettype wire

// ----- sv/dsvd_rho.sv -----
// Density and squared S speed ratio pipeline with integer square root.
`default_nettype none
module dsvd_rho
	import dsvd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [PW-1:0] p_in,
	output logic [PW-1:0]    p_out,
	output logic [19:0]      rho_out,
	output logic [PW-1:0]    s_out
);
	// Density: base + round(1579*p/10000), divider by constant via reciprocal
	logic [31:0] m_c;
	assign m_c = 32'(p_in) * 32'd1579 + 32'd5000;
	logic [31:0] m_s1;
	logic [PW-1:0] p_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= m_c;
			p_s1 <= p_in;
		end
	end
	// floor(m/10000) = (m * 3518437209) >> 45, exact for m < 2^32
	logic [63:0] qm_s2;
	logic [PW-1:0] p_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			qm_s2 <= 64'(m_s1) * 64'd3518437209;
			p_s2 <= p_s1;
		end
	end
	logic [19:0] rho_c;
	logic [16:0] x_c;
	logic [19:0] diff_c;
	always_comb begin
		rho_c = 20'(qm_s2[63:45]) + RhoBaseQ8;
		diff_c = rho_c - RhoLowQ8;
		if (rho_c < RhoLowQ8) x_c = '0;
		else if (diff_c > 20'(RhoSpanQ8)) x_c = RhoSpanQ8;
		else x_c = diff_c[16:0];
	end
	logic [19:0] rho_s3;
	logic [21:0] num_s3;
	logic [21:0] den_s3;
	logic [PW-1:0] p_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			rho_s3 <= rho_c;
			num_s3 <= 22'd225280 + 22'(x_c) * 22'd3;
			den_s3 <= 22'd1351680 + 22'(x_c) * 22'd3;
			p_s3 <= p_s2;
		end
	end
	// p squared times 4
	logic [43:0] psq_s4;
	logic [19:0] rho_s4;
	logic [21:0] num_s4;
	logic [21:0] den_s4;
	logic [PW-1:0] p_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			psq_s4 <= {44'(p_s3) * 44'(p_s3)} << 2;
			rho_s4 <= rho_s3; num_s4 <= num_s3; den_s4 <= den_s3; p_s4 <= p_s3;
		end
	end
	// Split psq*num into two partial products
	logic [43:0] pl_s5;
	logic [43:0] ph_s5;
	logic [19:0] rho_s5;
	logic [21:0] den_s5;
	logic [PW-1:0] p_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s5 <= 44'(psq_s4[21:0]) * 44'(num_s4);
			ph_s5 <= 44'(psq_s4[43:22]) * 44'(num_s4);
			rho_s5 <= rho_s4; den_s5 <= den_s4; p_s5 <= p_s4;
		end
	end
	logic [TW-1:0] prod_s6;
	logic [19:0] rho_s6;
	logic [21:0] den_s6;
	logic [PW-1:0] p_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s6 <= TW'(pl_s5) + (TW'(ph_s5) << 22);
			rho_s6 <= rho_s5; den_s6 <= den_s5; p_s6 <= p_s5;
		end
	end

	// Restoring division, one quotient bit per stage
	localparam int DS = TW;
	logic [22:0]   drem [DS+1];
	logic [TW-1:0] dquo [DS+1];
	logic [21:0]   dden [DS+1];
	logic [19:0]   drho [DS+1];
	logic [PW-1:0] dp   [DS+1];
	always_comb begin
		drem[0] = '0; dquo[0] = prod_s6; dden[0] = den_s6; drho[0] = rho_s6; dp[0] = p_s6;
	end
	for (genvar k = 0; k < DS; k++) begin : g_div
		logic [23:0] tr;
		assign tr = {drem[k], dquo[k][TW-1]} - {2'b0, dden[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!tr[23]) begin
					drem[k+1] <= tr[22:0];
					dquo[k+1] <= {dquo[k][TW-2:0], 1'b1};
				end else begin
					drem[k+1] <= {drem[k][21:0], dquo[k][TW-1]};
					dquo[k+1] <= {dquo[k][TW-2:0], 1'b0};
				end
				dden[k+1] <= dden[k]; drho[k+1] <= drho[k]; dp[k+1] <= dp[k];
			end
		end
	end

	// Integer square root, one result bit per stage
	localparam int SS = RW;
	logic [TW-1:0] sv   [SS+1];
	logic [TW-1:0] sres [SS+1];
	logic [19:0]   srho [SS+1];
	logic [PW-1:0] sp   [SS+1];
	always_comb begin
		sv[0] = dquo[DS]; sres[0] = '0; srho[0] = drho[DS]; sp[0] = dp[DS];
	end
	for (genvar k = 0; k < SS; k++) begin : g_sqrt
		localparam logic [TW-1:0] BIT = TW'(1) << (62 - 2 * k);
		logic [TW-1:0] cand;
		assign cand = sres[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (sv[k] >= cand) begin
					sv[k+1] <= sv[k] - cand;
					sres[k+1] <= (sres[k] >> 1) + BIT;
				end else begin
					sv[k+1] <= sv[k];
					sres[k+1] <= sres[k] >> 1;
				end
				srho[k+1] <= srho[k]; sp[k+1] <= sp[k];
			end
		end
	end
	logic [TW-1:0] sround;
	assign sround = (sres[SS] + TW'(1)) >> 1;
	assign s_out = sround[PW-1:0];
	assign rho_out = srho[SS];
	assign p_out = sp[SS];
endmodule
`default_nettype wire

// ----- sv/depth_to_seismic_velocity_density.sv -----
// Top level of the depth to seismic velocity and density pipeline.
// Usage:
//   Input channel: depth_q8 (signed Q23.8 metres) with valid/stall.
//   Output channel: p_speed_q8, density_q8, s_speed_q8 with out_valid/out_stall.
//   One result per depth, in order. A new depth may be taken every cycle.
//   The pipeline is built from two interpolation stages, a 35-stage
//   bit-per-cycle restoring divider, six density and product stages,
//   a 64-stage divider for the S ratio and a 32-stage square root unit.
//   Throughput is one item per cycle while out_stall is low.
//   While out_stall is high and a result is presented the whole pipeline
//   holds and in_stall is raised; nothing is dropped or repeated.
//   Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module depth_to_seismic_velocity_density
	import dsvd_pkg::*;
#(
	parameter int LAYER_COUNT = LayerCountDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] depth_q8,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [20:0]      p_speed_q8,
	output logic [19:0]      density_q8,
	output logic [20:0]      s_speed_q8
);
	localparam int LAT = 2 + 35 + 6 + TW + RW;

	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !en;

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	logic [PW-1:0] p_mid;
	dsvd_pvel #(.LAYER_COUNT(LAYER_COUNT)) u_pvel (
		.clk(clk), .en(en), .depth_q8(depth_q8), .p_out(p_mid)
	);
	dsvd_rho u_rho (
		.clk(clk), .en(en), .p_in(p_mid), .p_out(p_speed_q8),
		.rho_out(density_q8), .s_out(s_speed_q8)
	);
	assign out_valid = vld_q[LAT-1];
endmodule
`default_nettype wire

// ----- sv/dsvd_checker.sv -----
// Port-level checker for the depth to velocity and density block, with bind.
`default_nettype none
module dsvd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [20:0] p_speed_q8,
	input wire logic [19:0] density_q8,
	input wire logic [20:0] s_speed_q8
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(p_speed_q8) && $stable(s_speed_q8))
		else $error("result changed while stalled");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_srange: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> s_speed_q8 <= p_speed_q8)
		else $error("S speed above P speed");
	a_rho: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> density_q8 >= 20'd477440)
		else $error("density below base");
endmodule
bind depth_to_seismic_velocity_density dsvd_checker u_chk (.*);
`default_nettype wire
